/* hw/rtl/fir_filter_circular_mac_defines.svh */
// assertion helpers for the fir filter block
`ifndef FIR_FILTER_CIRCULAR_MAC_DEFINES_SVH
`define FIR_FILTER_CIRCULAR_MAC_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define FCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define FCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fcm_pkg.sv */
`default_nettype none

package fcm_pkg;

	// sizes of the filter
	localparam int MAX_TAPS     = 128;
	localparam int SAMPLE_BITS  = 16;
	localparam int COEF_BITS    = 18;
	localparam int TAP_AW       = $clog2(MAX_TAPS);
	localparam int TAPS_CNT_W   = $clog2(MAX_TAPS + 1);
	localparam int COEF_INDEX_W = 7;
	localparam int CMD_W        = 2;

	// tap count register
	localparam int                    TAPS_CFG_W = 8;
	localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 8'd101;

	// register bus
	localparam int                   APB_AW    = 3;
	localparam int                   APB_DW    = 32;
	localparam int                   REG_IDX_W = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_TAPS  = 1'd0;

	// arithmetic widths
	localparam int FRAC_SHIFT = COEF_BITS - 1;
	localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W      = PROD_W + TAP_AW + 1;
	localparam int RND_W      = ACC_W + 1;

	localparam logic signed [RND_W-1:0] ROUND_ADD = RND_W'(2 ** (FRAC_SHIFT - 1));
	localparam logic signed [RND_W-1:0] SAT_HI    = RND_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [RND_W-1:0] SAT_LO    = -RND_W'(2 ** (SAMPLE_BITS - 1));

	// item commands
	localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/fcm_ifs.sv */
`default_nettype none

// input item channel
interface fcm_item_if;
	logic                                       valid;
	logic                                       ready;
	logic [fcm_pkg::CMD_W-1:0]                  cmd;
	logic signed [fcm_pkg::SAMPLE_BITS-1:0]     sample_in;
	logic [fcm_pkg::COEF_INDEX_W-1:0]           coef_index;
	logic signed [fcm_pkg::COEF_BITS-1:0]       coef_value;

	modport source (output valid, cmd, sample_in, coef_index, coef_value, input ready);
	modport sink (input valid, cmd, sample_in, coef_index, coef_value, output ready);
endinterface

// result item channel
interface fcm_result_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [fcm_pkg::SAMPLE_BITS-1:0] sample_out;
	logic                                   saturated;

	modport source (output valid, sample_out, saturated, input ready);
	modport sink (input valid, sample_out, saturated, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fir_filter_circular_mac.sv */
`default_nettype none
`include "fir_filter_circular_mac_defines.svh"

// channel  | dir | payload                                   | handshake
// ---------+-----+-------------------------------------------+----------------------
// item     | in  | cmd, sample_in, coef_index, coef_value    | valid / ready
// result   | out | sample_out, saturated                     | valid / ready
// apb      | in  | taps_in_use at byte 0                     | psel/penable, pready=1
//
// a filter item holds the input off while the sequencer runs: one multiply-accumulate
// per tap on the shared multiplier, then the pipeline drains and the sum is rounded
// coefficient and clear items leave the sequencer idle; a clear drops the delay line valid bits
// reset clears the delay line and coefficient valid bits at once, no clearing pass
// the result sits in an output register, so the next item is taken while it waits
// a filter item only stalls in its last cycle if the previous result is still unread

module fir_filter_circular_mac (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fcm_pkg::APB_AW-1:0]    paddr,
	input  wire logic [fcm_pkg::APB_DW-1:0]    pwdata,
	output logic      [fcm_pkg::APB_DW-1:0]    prdata,
	output logic                               pready,
	fcm_item_if.sink                           item,
	fcm_result_if.source                       result
);

	fcm_pkg::state_t state_q, state_d;

	logic                               item_acc;
	logic                               is_filter;
	logic                               is_coef;
	logic                               is_clear;
	logic                               coef_idx_ok;
	logic                               cfg_wr;
	logic                               issue;
	logic                               load_out;

	logic [fcm_pkg::TAPS_CFG_W-1:0]     taps_q;
	logic [fcm_pkg::TAPS_CNT_W-1:0]     taps_eff;
	logic [fcm_pkg::TAP_AW-1:0]         wpos_q;
	logic [fcm_pkg::TAP_AW-1:0]         pos_next;
	logic [fcm_pkg::TAP_AW+1:0]         start_sum;
	logic [fcm_pkg::TAP_AW-1:0]         start_slot;
	logic [fcm_pkg::TAP_AW-1:0]         k_q;
	logic [fcm_pkg::TAP_AW-1:0]         last_k_q;
	logic [fcm_pkg::TAP_AW-1:0]         slot_q;

	logic [fcm_pkg::MAX_TAPS-1:0]       dl_vld_q;
	logic [fcm_pkg::MAX_TAPS-1:0]       cf_vld_q;

	logic [fcm_pkg::SAMPLE_BITS-1:0]    dl_rdata;
	logic [fcm_pkg::COEF_BITS-1:0]      cf_rdata;
	logic                               v_s1;
	logic                               v_s2;
	logic                               dl_ok_s1;
	logic                               cf_ok_s1;
	logic signed [fcm_pkg::SAMPLE_BITS-1:0] samp_s1;
	logic signed [fcm_pkg::COEF_BITS-1:0]   coef_s1;
	logic signed [fcm_pkg::PROD_W-1:0]  prod_s2;
	logic signed [fcm_pkg::ACC_W-1:0]   acc_q;

	logic signed [fcm_pkg::RND_W-1:0]   rnd;
	logic signed [fcm_pkg::RND_W-1:0]   shifted;
	logic                               clip_hi;
	logic                               clip_lo;

	logic                               out_v_q;
	logic signed [fcm_pkg::SAMPLE_BITS-1:0] out_sample_q;
	logic                               out_sat_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[fcm_pkg::APB_AW-1:2] == fcm_pkg::REG_TAPS) ?
		fcm_pkg::APB_DW'(taps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= fcm_pkg::TAPS_RESET;
		end else if (cfg_wr && paddr[fcm_pkg::APB_AW-1:2] == fcm_pkg::REG_TAPS) begin
			taps_q <= pwdata[fcm_pkg::TAPS_CFG_W-1:0];
		end
	end

	// item decode
	assign item.ready  = (state_q == fcm_pkg::ST_IDLE);
	assign item_acc    = item.valid && item.ready;
	assign is_filter   = item_acc && item.cmd == fcm_pkg::CMD_FILTER;
	assign is_coef     = item_acc && item.cmd == fcm_pkg::CMD_COEF;
	assign is_clear    = item_acc && item.cmd == fcm_pkg::CMD_CLEAR;
	assign coef_idx_ok = 32'(item.coef_index) < fcm_pkg::MAX_TAPS;

	// tap count clamped to 1 .. max
	always_comb begin
		if (taps_q == '0) begin
			taps_eff = fcm_pkg::TAPS_CNT_W'(1);
		end else if (32'(taps_q) > fcm_pkg::MAX_TAPS) begin
			taps_eff = fcm_pkg::TAPS_CNT_W'(fcm_pkg::MAX_TAPS);
		end else begin
			taps_eff = fcm_pkg::TAPS_CNT_W'(taps_q);
		end
	end

	// next write slot and oldest active slot behind it
	assign pos_next = (wpos_q == fcm_pkg::TAP_AW'(fcm_pkg::MAX_TAPS - 1)) ? '0 : wpos_q + 1'b1;
	assign start_sum = (fcm_pkg::TAP_AW+2)'(pos_next) + (fcm_pkg::TAP_AW+2)'(fcm_pkg::MAX_TAPS)
		- (fcm_pkg::TAP_AW+2)'(taps_eff);
	assign start_slot = (start_sum >= (fcm_pkg::TAP_AW+2)'(fcm_pkg::MAX_TAPS)) ?
		fcm_pkg::TAP_AW'(start_sum - (fcm_pkg::TAP_AW+2)'(fcm_pkg::MAX_TAPS)) :
		fcm_pkg::TAP_AW'(start_sum);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			fcm_pkg::ST_IDLE: begin
				if (is_filter) begin
					state_d = fcm_pkg::ST_MAC;
				end
			end
			fcm_pkg::ST_MAC: begin
				issue = 1'b1;
				if (k_q == last_k_q) begin
					state_d = fcm_pkg::ST_DRAIN;
				end
			end
			fcm_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = fcm_pkg::ST_FINISH;
				end
			end
			fcm_pkg::ST_FINISH: begin
				if (!out_v_q || result.ready) begin
					load_out = 1'b1;
					state_d  = fcm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fcm_pkg::ST_IDLE;
			end
		endcase
	end

	// write position and tap walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= '0;
			k_q      <= '0;
			last_k_q <= '0;
			slot_q   <= '0;
		end else if (is_filter) begin
			wpos_q   <= pos_next;
			k_q      <= '0;
			last_k_q <= fcm_pkg::TAP_AW'(taps_eff - 1'b1);
			slot_q   <= start_slot;
		end else if (issue) begin
			k_q    <= k_q + 1'b1;
			slot_q <= (slot_q == fcm_pkg::TAP_AW'(fcm_pkg::MAX_TAPS - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// entry valid bits, an invalid entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_vld_q <= '0;
			cf_vld_q <= '0;
		end else begin
			if (is_clear) begin
				dl_vld_q <= '0;
			end else if (is_filter) begin
				dl_vld_q[wpos_q] <= 1'b1;
			end
			if (is_coef && coef_idx_ok) begin
				cf_vld_q[fcm_pkg::TAP_AW'(item.coef_index)] <= 1'b1;
			end
		end
	end

	// delay line and coefficient stores
	fcm_ram #(
		.WIDTH(fcm_pkg::SAMPLE_BITS),
		.DEPTH(fcm_pkg::MAX_TAPS)
	) u_dl_ram (
		.clk  (clk),
		.we   (is_filter),
		.waddr(wpos_q),
		.wdata(item.sample_in),
		.re   (issue),
		.raddr(slot_q),
		.rdata(dl_rdata)
	);

	fcm_ram #(
		.WIDTH(fcm_pkg::COEF_BITS),
		.DEPTH(fcm_pkg::MAX_TAPS)
	) u_cf_ram (
		.clk  (clk),
		.we   (is_coef && coef_idx_ok),
		.waddr(fcm_pkg::TAP_AW'(item.coef_index)),
		.wdata(item.coef_value),
		.re   (issue),
		.raddr(k_q),
		.rdata(cf_rdata)
	);

	// mac pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// operands masked by their valid bits
	assign samp_s1 = dl_ok_s1 ? $signed(dl_rdata) : '0;
	assign coef_s1 = cf_ok_s1 ? $signed(cf_rdata) : '0;

	// shared multiplier and accumulator
	always_ff @(posedge clk) begin
		if (issue) begin
			dl_ok_s1 <= dl_vld_q[slot_q];
			cf_ok_s1 <= cf_vld_q[k_q];
		end
		prod_s2 <= coef_s1 * samp_s1;
		if (is_filter) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + fcm_pkg::ACC_W'(prod_s2);
		end
	end

	// round half up, drop fraction bits, clip to sample range
	assign rnd     = $signed({acc_q[fcm_pkg::ACC_W-1], acc_q}) + fcm_pkg::ROUND_ADD;
	assign shifted = rnd >>> fcm_pkg::FRAC_SHIFT;
	assign clip_hi = shifted > fcm_pkg::SAT_HI;
	assign clip_lo = shifted < fcm_pkg::SAT_LO;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sat_q <= clip_hi || clip_lo;
			if (clip_hi) begin
				out_sample_q <= fcm_pkg::SAMPLE_BITS'(fcm_pkg::SAT_HI);
			end else if (clip_lo) begin
				out_sample_q <= fcm_pkg::SAMPLE_BITS'(fcm_pkg::SAT_LO);
			end else begin
				out_sample_q <= fcm_pkg::SAMPLE_BITS'(shifted);
			end
		end
	end

	assign result.valid      = out_v_q;
	assign result.sample_out = out_sample_q;
	assign result.saturated  = out_sat_q;

	// checks
	`FCM_ASSERT_NEXT(a_filter_starts_clean, clk, arst_n, is_filter,
		state_q == fcm_pkg::ST_MAC && acc_q == '0 && k_q == '0,
		"filter item did not start a fresh tap walk")
	`FCM_ASSERT_NOW(a_tap_walk_bounded, clk, arst_n, state_q == fcm_pkg::ST_MAC,
		k_q <= last_k_q, "tap counter ran past the last active tap")
	`FCM_ASSERT_NOW(a_idle_pipe_empty, clk, arst_n, state_q == fcm_pkg::ST_IDLE,
		!v_s1 && !v_s2, "mac pipeline busy while idle")
	`FCM_ASSERT_NEXT(a_short_items_stay_idle, clk, arst_n, is_coef || is_clear,
		state_q == fcm_pkg::ST_IDLE, "coefficient or clear item left idle")

endmodule

`default_nettype wire

/* hw/rtl/fcm_ram.sv */
`default_nettype none

// simple dual-port ram, registered read
module fcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
